// ----- sv/orc_pkg.sv -----
// Shared types, codes and constants of the order risk check and lifecycle block.
package orc_pkg;

  localparam int unsigned OrderSlotsDefault = 256;
  localparam logic [13:0] BpsScale = 14'd10000;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_QTY      = 3'd0,
    CFG_MAX_NOTIONAL = 3'd1,
    CFG_MAX_POS      = 3'd2,
    CFG_FAT_BPS      = 3'd3,
    CFG_REF_PRICE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_ACKED    = 3'd1,
    ST_PARTIAL  = 3'd2,
    ST_FILLED   = 3'd3,
    ST_CANCELED = 3'd4,
    ST_REJECTED = 3'd5
  } ord_status_e;

  typedef enum logic [2:0] {
    RJ_NONE     = 3'd0,
    RJ_ZERO_QTY = 3'd1,
    RJ_QTY      = 3'd2,
    RJ_NOTIONAL = 3'd3,
    RJ_POSITION = 3'd4,
    RJ_BAD_REF  = 3'd5,
    RJ_FAT      = 3'd6,
    RJ_EXCHANGE = 3'd7
  } reject_e;

  typedef enum logic [2:0] {
    ER_OK        = 3'd0,
    ER_UNKNOWN   = 3'd1,
    ER_TERMINAL  = 3'd2,
    ER_WRONG     = 3'd3,
    ER_ZERO_FILL = 3'd4,
    ER_OVERFILL  = 3'd5,
    ER_FULL      = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    EV_ACK     = 3'd0,
    EV_PARTIAL = 3'd1,
    EV_FILL    = 3'd2,
    EV_CANCEL  = 3'd3,
    EV_REJECT  = 3'd4
  } event_e;

  localparam logic CMD_SUBMIT = 1'b0;

  typedef struct packed {
    logic [0:0]  command;
    logic [0:0]  side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [7:0]  order_index;
    logic [2:0]  event_kind;
    logic [31:0] fill_quantity;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         slot;
    logic [2:0]         order_status;
    logic [2:0]         reject_code;
    logic [2:0]         error_code;
    logic [31:0]        filled_total;
    logic signed [47:0] net_position;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // register input item, start table read
    logic commit;   // decide, write back, load result
  } dp_cmd_t;

endpackage

// ----- sv/orc_stream_if.sv -----
// Valid/ready channel carrying one payload item.
interface orc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/orc_ctrl.sv -----
// Controller: sequences capture and commit of one item and holds the result.
module orc_ctrl
  import orc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   free;

  // The result register may be refilled once its current content transfers.
  assign free        = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/orc_datapath.sv -----
// Datapath: configuration, order table, risk checks, lifecycle and position.
module orc_datapath
  import orc_pkg::*;
#(
  parameter int unsigned OrderSlots = OrderSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            item_i,
  input  dp_cmd_t             cmd_i,
  output out_item_t           result_o
);

  localparam int unsigned SlotW = $clog2(OrderSlots);
  localparam int unsigned CntW  = SlotW + 1;
  localparam logic [CntW-1:0] SlotsFull = CntW'(OrderSlots);
  localparam logic signed [48:0] PosMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] PosMin = -49'sh0_8000_0000_0000;

  // Configuration.
  logic [31:0] max_qty_q;
  logic [63:0] max_notional_q;
  logic [46:0] max_pos_q;
  logic [19:0] fat_bps_q;
  logic [31:0] ref_price_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_qty_q      <= '0;
      max_notional_q <= '0;
      max_pos_q      <= '0;
      fat_bps_q      <= '0;
      ref_price_q    <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_QTY:      max_qty_q      <= cfg_data_i[31:0];
        CFG_MAX_NOTIONAL: max_notional_q <= cfg_data_i;
        CFG_MAX_POS:      max_pos_q      <= cfg_data_i[46:0];
        CFG_FAT_BPS:      fat_bps_q      <= cfg_data_i[19:0];
        CFG_REF_PRICE:    ref_price_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Order table memory.
  logic [31:0] mem_qty  [OrderSlots];
  logic [31:0] mem_fill [OrderSlots];
  logic [2:0]  mem_stat [OrderSlots];
  logic        mem_side [OrderSlots];
  logic [31:0] rd_qty_q, rd_fill_q;
  logic [2:0]  rd_stat_q;
  logic        rd_side_q;

  logic              we;
  logic [SlotW-1:0]  wa;
  logic [31:0]       wd_qty, wd_fill;
  logic [2:0]        wd_stat;
  logic              wd_side, we_qty_side;

  logic [SlotW-1:0] rd_addr;
  assign rd_addr = SlotW'(item_i.order_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_qty_q  <= mem_qty[rd_addr];
      rd_fill_q <= mem_fill[rd_addr];
      rd_stat_q <= mem_stat[rd_addr];
      rd_side_q <= mem_side[rd_addr];
    end
    if (we) begin
      mem_fill[wa] <= wd_fill;
      mem_stat[wa] <= wd_stat;
      if (we_qty_side) begin
        mem_qty[wa]  <= wd_qty;
        mem_side[wa] <= wd_side;
      end
    end
  end

  // Captured item and first-cycle products.
  in_item_t    it_q;
  logic [63:0] notional_q;
  logic [45:0] dev_scaled_q;
  logic [51:0] ff_limit_q;
  logic signed [48:0] proj_q;
  logic [31:0] dev;

  assign dev = (item_i.price > ref_price_q) ? (item_i.price - ref_price_q)
                                            : (ref_price_q - item_i.price);

  logic signed [47:0] pos_q;
  logic [CntW-1:0]    used_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_q         <= item_i;
      notional_q   <= 64'(item_i.price) * 64'(item_i.quantity);
      dev_scaled_q <= 46'(dev) * 46'(BpsScale);
      ff_limit_q   <= 52'(fat_bps_q) * 52'(ref_price_q);
      proj_q       <= item_i.side ? 49'(pos_q) - $signed({17'd0, item_i.quantity})
                                  : 49'(pos_q) + $signed({17'd0, item_i.quantity});
    end
  end

  // Commit logic.
  logic [47:0] proj_mag;
  reject_e     rcode;
  logic        known;
  logic [32:0] amt, new_fill;
  logic signed [48:0] pos_sum;
  logic signed [47:0] pos_next;
  logic        pos_upd;
  out_item_t   res_d, res_q;

  assign proj_mag = proj_q[48] ? 48'(-proj_q) : 48'(proj_q);
  assign known = (32'(it_q.order_index) < 32'(used_q));

  always_comb begin
    priority if (it_q.quantity == '0)                  rcode = RJ_ZERO_QTY;
    else if (it_q.quantity > max_qty_q)                rcode = RJ_QTY;
    else if (notional_q > max_notional_q)              rcode = RJ_NOTIONAL;
    else if (proj_mag > {1'b0, max_pos_q})             rcode = RJ_POSITION;
    else if (ref_price_q == '0)                        rcode = RJ_BAD_REF;
    else if (52'(dev_scaled_q) > ff_limit_q)           rcode = RJ_FAT;
    else                                               rcode = RJ_NONE;
  end

  always_comb begin
    res_d       = '0;
    res_d.net_position = pos_q;
    we          = 1'b0;
    we_qty_side = 1'b0;
    wa          = used_q[SlotW-1:0];
    wd_qty      = it_q.quantity;
    wd_side     = it_q.side;
    wd_fill     = '0;
    wd_stat     = ST_PENDING;
    pos_upd     = 1'b0;
    amt         = '0;
    new_fill    = '0;
    if (it_q.command == CMD_SUBMIT) begin
      if (used_q >= SlotsFull) begin
        res_d.order_status = ST_REJECTED;
        res_d.error_code   = ER_FULL;
      end else begin
        res_d.slot         = 8'(used_q);
        res_d.reject_code  = rcode;
        res_d.order_status = (rcode != RJ_NONE) ? ST_REJECTED : ST_PENDING;
        we          = 1'b1;
        we_qty_side = 1'b1;
        wd_stat     = res_d.order_status;
      end
    end else begin
      res_d.slot = it_q.order_index;
      wa         = SlotW'(it_q.order_index);
      if (!known) begin
        res_d.error_code = ER_UNKNOWN;
      end else begin
        res_d.order_status = rd_stat_q;
        res_d.filled_total = rd_fill_q;
        wd_fill            = rd_fill_q;
        amt = (it_q.event_kind == EV_FILL)
            ? ((rd_qty_q > rd_fill_q) ? 33'(rd_qty_q - rd_fill_q) : '0)
            : 33'(it_q.fill_quantity);
        new_fill = 33'(rd_fill_q) + amt;
        if (rd_stat_q == ST_FILLED || rd_stat_q == ST_CANCELED ||
            rd_stat_q == ST_REJECTED) begin
          res_d.error_code = ER_TERMINAL;
        end else if (it_q.event_kind == EV_ACK) begin
          if (rd_stat_q != ST_PENDING) res_d.error_code = ER_WRONG;
          else res_d.order_status = ST_ACKED;
        end else if (it_q.event_kind == EV_PARTIAL || it_q.event_kind == EV_FILL) begin
          if (rd_stat_q != ST_ACKED && rd_stat_q != ST_PARTIAL)
            res_d.error_code = ER_WRONG;
          else if (amt == '0)
            res_d.error_code = ER_ZERO_FILL;
          else if (new_fill > 33'(rd_qty_q))
            res_d.error_code = ER_OVERFILL;
          else begin
            res_d.filled_total = new_fill[31:0];
            wd_fill = new_fill[31:0];
            res_d.order_status = (it_q.event_kind == EV_FILL ||
                                  new_fill >= 33'(rd_qty_q)) ? ST_FILLED : ST_PARTIAL;
            pos_upd = 1'b1;
          end
        end else if (it_q.event_kind == EV_CANCEL) begin
          res_d.order_status = ST_CANCELED;
        end else if (it_q.event_kind == EV_REJECT) begin
          res_d.order_status = ST_REJECTED;
          res_d.reject_code  = RJ_EXCHANGE;
        end else begin
          res_d.error_code = ER_UNKNOWN;
        end
        wd_stat = res_d.order_status;
        we      = (res_d.error_code == ER_OK);
      end
    end
    if (!cmd_i.commit) we = 1'b0;
  end

  // Saturating position update.
  assign pos_sum = rd_side_q ? 49'(pos_q) - $signed({16'd0, amt})
                             : 49'(pos_q) + $signed({16'd0, amt});
  always_comb begin
    priority if (pos_sum > PosMax) pos_next = 48'(PosMax);
    else if (pos_sum < PosMin)     pos_next = 48'(PosMin);
    else                           pos_next = 48'(pos_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      used_q <= '0;
    end else if (cmd_i.commit) begin
      if (pos_upd) pos_q <= pos_next;
      if (we_qty_side && we) used_q <= used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
      if (pos_upd) res_q.net_position <= pos_next;
    end
  end

  assign result_o = res_q;

endmodule

// ----- sv/order_risk_check_and_lifecycle.sv -----
// Top level: pre-trade risk check and order lifecycle table.
// Sequence: capture and table read at the input transfer edge, then check, commit and
// result register load at a later edge, once the result register is free to refill.
// Input: a new item is accepted only after the previous one has committed (table read-modify-write).
// Reset: asynchronous, active low; clears configuration to defaults, slot count
// and net position; the order table itself is not cleared.
module order_risk_check_and_lifecycle
  import orc_pkg::*;
#(
  parameter int unsigned OrderSlots = OrderSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  orc_stream_if.sink          in_if,
  orc_stream_if.source        out_if
);

  dp_cmd_t   cmd;
  in_item_t  item;
  out_item_t result;

  assign item = in_item_t'(in_if.data);

  orc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  orc_datapath #(
    .OrderSlots (OrderSlots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .cmd_i      (cmd),
    .result_o   (result)
  );

  assign out_if.data = result;

  // A commit always loads the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_if.valid)
    else $error("commit did not raise result valid");

  // Capture and commit never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  // A captured item commits in a later cycle, never while input is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_if.ready)
    else $error("input ready while item in flight");

endmodule

// ----- tb/tb_order_risk_check_and_lifecycle.sv -----
// Self-checking testbench for the order risk check and lifecycle block.
module tb_order_risk_check_and_lifecycle;
  import orc_pkg::*;

  localparam int unsigned TableDepth = OrderSlotsDefault;
  localparam int unsigned HoldCycles = 300;
  localparam longint     PosMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint     PosMin = -PosMax - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  orc_stream_if #(.payload_t(in_item_t))  in_ch ();
  orc_stream_if #(.payload_t(out_item_t)) out_ch ();

  order_risk_check_and_lifecycle DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Predicted block state and limits
  logic [31:0]  lim_qty;
  logic [63:0]  lim_notional;
  logic [46:0]  lim_pos;
  logic [19:0]  lim_bps;
  logic [31:0]  ref_px;
  logic [31:0]  book_qty [TableDepth];
  logic [31:0]  book_filled [TableDepth];
  ord_status_e  book_status [TableDepth];
  logic         book_side [TableDepth];
  int unsigned  orders_used;
  longint       net_pos;

  out_item_t    pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  items_sent = 0;
  int unsigned  fills_seen = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  bit           hold_req = 1'b0;
  logic         rx_hold = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    lim_qty = '0;
    lim_notional = '0;
    lim_pos = '0;
    lim_bps = '0;
    ref_px = 32'd1;
    orders_used = 0;
    net_pos = 0;
  end

  // Apply one item to the predicted order book and return the result
  function automatic out_item_t book_apply(in_item_t it);
    out_item_t   r;
    logic [63:0] q, p, dev, amt, of, oq;
    longint      proj, mag, npos;
    reject_e     rj;
    ord_status_e st;
    err_e        er;
    int unsigned ix;
    r = '0;
    er = ER_OK;
    rj = RJ_NONE;
    if (it.command == CMD_SUBMIT) begin
      if (orders_used >= TableDepth) begin
        r.order_status = ST_REJECTED;
        er = ER_FULL;
      end else begin
        q = 64'(it.quantity);
        p = 64'(it.price);
        proj = net_pos + (it.side ? -longint'(q) : longint'(q));
        mag = proj < 0 ? -proj : proj;
        dev = p > 64'(ref_px) ? p - 64'(ref_px) : 64'(ref_px) - p;
        if (q == 0) rj = RJ_ZERO_QTY;
        else if (q > 64'(lim_qty)) rj = RJ_QTY;
        else if (p * q > lim_notional) rj = RJ_NOTIONAL;
        else if (mag > longint'(lim_pos)) rj = RJ_POSITION;
        else if (ref_px == 0) rj = RJ_BAD_REF;
        else if (dev * 64'(BpsScale) > 64'(lim_bps) * 64'(ref_px)) rj = RJ_FAT;
        st = (rj != RJ_NONE) ? ST_REJECTED : ST_PENDING;
        book_qty[orders_used] = it.quantity;
        book_filled[orders_used] = '0;
        book_status[orders_used] = st;
        book_side[orders_used] = it.side;
        r.slot = orders_used[7:0];
        r.order_status = st;
        orders_used++;
      end
    end else begin
      ix = it.order_index;
      r.slot = it.order_index;
      if (ix >= orders_used) begin
        er = ER_UNKNOWN;
      end else begin
        st = book_status[ix];
        oq = 64'(book_qty[ix]);
        of = 64'(book_filled[ix]);
        r.filled_total = book_filled[ix];
        if (st inside {ST_FILLED, ST_CANCELED, ST_REJECTED}) begin
          er = ER_TERMINAL;
        end else if (it.event_kind == EV_ACK) begin
          if (st != ST_PENDING) er = ER_WRONG;
          else st = ST_ACKED;
        end else if (it.event_kind == EV_PARTIAL || it.event_kind == EV_FILL) begin
          amt = (it.event_kind == EV_FILL) ? (oq > of ? oq - of : 0) : 64'(it.fill_quantity);
          if (st != ST_ACKED && st != ST_PARTIAL) er = ER_WRONG;
          else if (amt == 0) er = ER_ZERO_FILL;
          else if (of + amt > oq) er = ER_OVERFILL;
          else begin
            r.filled_total = 32'(of + amt);
            st = (it.event_kind == EV_FILL || of + amt >= oq) ? ST_FILLED : ST_PARTIAL;
            book_filled[ix] = r.filled_total;
            npos = net_pos + (book_side[ix] ? -longint'(amt) : longint'(amt));
            net_pos = npos > PosMax ? PosMax : (npos < PosMin ? PosMin : npos);
            fills_seen++;
          end
        end else if (it.event_kind == EV_CANCEL) begin
          st = ST_CANCELED;
        end else if (it.event_kind == EV_REJECT) begin
          st = ST_REJECTED;
          rj = RJ_EXCHANGE;
        end else begin
          er = ER_UNKNOWN;
        end
        if (er == ER_OK) book_status[ix] = st;
        r.order_status = (er == ER_OK) ? st : book_status[ix];
      end
    end
    r.reject_code = rj;
    r.error_code = er;
    r.net_position = net_pos[47:0];
    return r;
  endfunction

  // Offer one item; returns at the edge where the transfer happens
  task automatic send_item(in_item_t it);
    bit hit;
    if (tx_idle_en) begin
      while ($urandom_range(99) < 27) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    forever begin
      @(negedge clk_i);
      hit = in_ch.ready;
      @(posedge clk_i);
      if (hit) break;
    end
    pending_results.push_back(book_apply(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e ix, logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ix;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (ix)
      CFG_MAX_QTY:      lim_qty = v[31:0];
      CFG_MAX_NOTIONAL: lim_notional = v;
      CFG_MAX_POS:      lim_pos = v[46:0];
      CFG_FAT_BPS:      lim_bps = v[19:0];
      CFG_REF_PRICE:    ref_px = v[31:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] q, logic [63:0] n, logic [46:0] pos, logic [19:0] bps,
                         logic [31:0] rp);
    cfg_write(CFG_MAX_QTY, 64'(q));
    cfg_write(CFG_MAX_NOTIONAL, n);
    cfg_write(CFG_MAX_POS, 64'(pos));
    cfg_write(CFG_FAT_BPS, 64'(bps));
    cfg_write(CFG_REF_PRICE, 64'(rp));
  endtask

  function automatic in_item_t submit_item(logic sd, logic [31:0] px, logic [31:0] q);
    in_item_t it;
    it = '0;
    it.command = 1'b0;
    it.side = sd;
    it.price = px;
    it.quantity = q;
    return it;
  endfunction

  function automatic in_item_t event_item(int unsigned ix, logic [2:0] kind, logic [31:0] fq);
    in_item_t it;
    it = '0;
    it.command = 1'b1;
    it.order_index = ix[7:0];
    it.event_kind = kind;
    it.fill_quantity = fq;
    return it;
  endfunction

  // Random item: mostly well-formed lifecycle steps on live orders
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned ix;
    logic [31:0] left;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    if ((orders_used < TableDepth && $urandom_range(99) < 20) || $urandom_range(99) < 2) begin
      it.command = 1'b0;
      case ($urandom_range(9))
        0:       it.quantity = $urandom;
        1:       it.quantity = '0;
        default: it.quantity = $urandom_range(1, 5000);
      endcase
      if ($urandom_range(9) != 0) it.price = ref_px + $urandom_range(40) - 20;
      return it;
    end
    it.command = 1'b1;
    if (orders_used == 0 || $urandom_range(99) < 8) return it;
    ix = $urandom_range(orders_used - 1);
    it.order_index = ix[7:0];
    if ($urandom_range(99) < 25) return it;
    left = book_qty[ix] - book_filled[ix];
    case (book_status[ix])
      ST_PENDING: it.event_kind = ($urandom_range(9) == 0) ? EV_CANCEL : EV_ACK;
      ST_ACKED, ST_PARTIAL: begin
        case ($urandom_range(9))
          0:       it.event_kind = EV_FILL;
          1:       it.event_kind = EV_CANCEL;
          2:       it.event_kind = EV_REJECT;
          default: begin
            it.event_kind = EV_PARTIAL;
            it.fill_quantity = (left > 1) ? $urandom_range(1, (left > 50) ? left / 3 : left)
                                          : left;
          end
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    out_ch.ready <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 27);
  end

  initial begin
    forever begin
      wait (hold_req);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(negedge clk_i) begin
    out_item_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with none expected: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot || got.order_status !== want.order_status ||
            got.reject_code !== want.reject_code || got.error_code !== want.error_code ||
            got.filled_total !== want.filled_total || got.net_position !== want.net_position)
        begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: mismatch at %0t", $time);
            $display("  exp slot %0d st %0d rej %0d err %0d filled %0d pos %0d", want.slot,
                     want.order_status, want.reject_code, want.error_code, want.filled_total,
                     want.net_position);
            $display("  got slot %0d st %0d rej %0d err %0d filled %0d pos %0d", got.slot,
                     got.order_status, got.reject_code, got.error_code, got.filled_total,
                     got.net_position);
          end
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_item(submit_item(1'b0, 32'd100, 32'd0));
    send_item(submit_item(1'b0, 32'd100, 32'd5));
    send_item(event_item(200, EV_ACK, 32'd0));
    send_item(event_item(0, EV_ACK, 32'd0));
    wait_idle();
  endtask

  task automatic test_risk_checks();
    cfg_all('1, '1, '1, 20'd1000000, 32'd1000);
    send_item(submit_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(submit_item(1'b1, 32'd0, 32'd100));
    send_item(submit_item(1'b0, 32'd1000, 32'd100));
    wait_idle();
    cfg_write(CFG_MAX_NOTIONAL, 64'd50000);
    send_item(submit_item(1'b0, 32'd1000, 32'd100));
    wait_idle();
    cfg_write(CFG_MAX_NOTIONAL, '1);
    cfg_write(CFG_MAX_POS, 64'd50);
    send_item(submit_item(1'b0, 32'd1000, 32'd100));
    wait_idle();
    cfg_write(CFG_MAX_POS, 64'h7FFF_FFFF_FFFF);
    cfg_write(CFG_MAX_QTY, 64'd10);
    send_item(submit_item(1'b0, 32'd1000, 32'd11));
    wait_idle();
    cfg_write(CFG_MAX_QTY, 64'hFFFF_FFFF);
    cfg_write(CFG_REF_PRICE, 64'd0);
    send_item(submit_item(1'b1, 32'd1000, 32'd7));
    wait_idle();
    cfg_write(CFG_REF_PRICE, 64'd1000);
    cfg_write(CFG_FAT_BPS, 64'd100);
    send_item(submit_item(1'b0, 32'd1011, 32'd3));
    send_item(submit_item(1'b0, 32'd1010, 32'd3));
    wait_idle();
  endtask

  task automatic test_lifecycle();
    int unsigned s;
    cfg_write(CFG_FAT_BPS, 64'd1000000);
    s = orders_used;
    send_item(submit_item(1'b0, 32'd1000, 32'd100));
    send_item(event_item(s, EV_PARTIAL, 32'd10));
    send_item(event_item(s, EV_ACK, 32'd0));
    send_item(event_item(s, EV_ACK, 32'd0));
    send_item(event_item(s, EV_PARTIAL, 32'd0));
    send_item(event_item(s, EV_PARTIAL, 32'hFFFF_FFFF));
    send_item(event_item(s, EV_PARTIAL, 32'd40));
    send_item(event_item(s, EV_FILL, 32'd0));
    send_item(event_item(s, EV_CANCEL, 32'd0));
    send_item(submit_item(1'b1, 32'd990, 32'd10));
    send_item(event_item(s + 1, EV_ACK, 32'd0));
    send_item(event_item(s + 1, EV_CANCEL, 32'd0));
    send_item(submit_item(1'b0, 32'd1005, 32'd20));
    send_item(event_item(s + 2, EV_REJECT, 32'd0));
    send_item(submit_item(1'b1, 32'd1000, 32'd30));
    send_item(event_item(s + 3, 3'd7, 32'd0));
    send_item(event_item(s + 3, 3'd5, 32'd0));
    wait_idle();
  endtask

  task automatic test_random_phase(int unsigned count, bit idle_en);
    logic [31:0] rp;
    rp = $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(100, 100000);
    cfg_all(($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF,
            ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'hFFFF_FFFF_FFFF_FFFF,
            ($urandom_range(3) == 0) ? 47'($urandom_range(1000, 200000)) : 47'h7FFF_FFFF_FFFF,
            20'($urandom_range(50, 1000000)), rp);
    tx_idle_en = idle_en;
    rx_idle_en = idle_en;
    repeat (count) send_item(random_item());
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_item(random_item());
    wait_idle();
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_risk_checks();
    test_lifecycle();
    test_random_phase(420, 1'b1);
    test_backpressure();
    test_random_phase(420, 1'b0);
    test_random_phase(420, 1'b1);
    test_random_phase(420, 1'b1);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items, %0d results, %0d fills, %0d of %0d order slots used.",
             items_sent, results_seen, fills_seen, orders_used, TableDepth);
    $display("Ran risk limits at their extremes, every lifecycle event and a long stall.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches %0d, results still expected %0d", mismatches,
               pending_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/orc_pkg.sv
sv/orc_stream_if.sv
sv/orc_ctrl.sv
sv/orc_datapath.sv
sv/order_risk_check_and_lifecycle.sv
tb/tb_order_risk_check_and_lifecycle.sv
